[hw/rtl/bfw_pkg.sv]
// ----------------------------------------------------------------------------
// bfw_pkg
// Shared constants for the bilinear frame warp: field widths, register
// indexes, command codes and defaults for the frame limits.
// ----------------------------------------------------------------------------
package bfw_pkg;

    // Default frame limits
    localparam int DEF_MAX_WIDTH  = 512;
    localparam int DEF_MAX_HEIGHT = 512;

    // Field widths
    localparam int PIX_W      = 8;
    localparam int ADDR_W     = 18;
    localparam int COORD_W    = 9;
    localparam int WEIGHT_W   = 8;
    localparam int CFG_DATA_W = 10;
    localparam int CFG_IDX_W  = 1;

    // Weighted sum of four corners
    localparam int PROD_W = PIX_W + WEIGHT_W;
    localparam int SUM_W  = PROD_W + 2;

    localparam logic [PIX_W-1:0] PIX_MAX = 8'hFF;

    // Register values after reset
    localparam int RESET_WIDTH  = 320;
    localparam int RESET_HEIGHT = 240;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

    // Commands
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_WARP  = 1'b1;

endpackage

[hw/rtl/bfw_frame_mem.sv]
// ----------------------------------------------------------------------------
// bfw_frame_mem
// Pixel memory holding both frame buffers: one write port and two read
// ports, read data registered (old data on collision).
// ----------------------------------------------------------------------------
module bfw_frame_mem #(
    parameter int ADDR_BITS = 19
) (
    input  logic                       clk,
    input  logic                       wr_en,
    input  logic [ADDR_BITS-1:0]       wr_addr,
    input  logic [bfw_pkg::PIX_W-1:0]  wr_data,
    input  logic                       rd_en,
    input  logic [ADDR_BITS-1:0]       rd_addr_a,
    input  logic [ADDR_BITS-1:0]       rd_addr_b,
    output logic [bfw_pkg::PIX_W-1:0]  rd_data_a,
    output logic [bfw_pkg::PIX_W-1:0]  rd_data_b
);
    import bfw_pkg::*;

    localparam int DEPTH = 2 ** ADDR_BITS;

    logic [PIX_W-1:0] frame_ram [DEPTH];
    logic [PIX_W-1:0] rd_a_reg;
    logic [PIX_W-1:0] rd_b_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            frame_ram[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_a_reg <= frame_ram[rd_addr_a];
            rd_b_reg <= frame_ram[rd_addr_b];
        end
    end

    assign rd_data_a = rd_a_reg;
    assign rd_data_b = rd_b_reg;

endmodule

[hw/rtl/bilinear_frame_warp.sv]
// ----------------------------------------------------------------------------
// bilinear_frame_warp
// Bilinear warp of 8-bit grey frames between a front and a back buffer.
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+---------------------------
//   in      | sink      | in_valid / in_stall   | command, pixel_addr,
//           |           |                       | pixel_value, src_x, src_y,
//           |           |                       | weight_tl/tr/bl/br
//   out     | source    | out_valid / out_stall | out_pixel, dest_addr,
//           |           |                       | frame_done
//   cfg     | sink      | cfg_write             | cfg_index, cfg_data
//
// One transaction per cycle unless stalled; a warp result is registered out.
// A warp whose neighbour read hits a pixel write still in flight (two stages
// between the read and the write port) waits in stage 1 for that write.
// Two copies of the frame memory serve the top and bottom neighbour rows.
// Reset clears control state only; frame memory contents start undefined.
// Output stalls back up through the pipeline only once all stages are full.
// ----------------------------------------------------------------------------
module bilinear_frame_warp #(
    parameter int MAX_WIDTH  = bfw_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = bfw_pkg::DEF_MAX_HEIGHT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // configuration
    input  logic                              cfg_write,
    input  logic [bfw_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [bfw_pkg::CFG_DATA_W-1:0]    cfg_data,
    // input channel
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              command,
    input  logic [bfw_pkg::ADDR_W-1:0]        pixel_addr,
    input  logic [bfw_pkg::PIX_W-1:0]         pixel_value,
    input  logic [bfw_pkg::COORD_W-1:0]       src_x,
    input  logic [bfw_pkg::COORD_W-1:0]       src_y,
    input  logic [bfw_pkg::WEIGHT_W-1:0]      weight_tl,
    input  logic [bfw_pkg::WEIGHT_W-1:0]      weight_tr,
    input  logic [bfw_pkg::WEIGHT_W-1:0]      weight_bl,
    input  logic [bfw_pkg::WEIGHT_W-1:0]      weight_br,
    // output channel
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [bfw_pkg::PIX_W-1:0]         out_pixel,
    output logic [bfw_pkg::ADDR_W-1:0]        dest_addr,
    output logic                              frame_done
);
    import bfw_pkg::*;

    localparam int FRAME_WORDS = MAX_WIDTH * MAX_HEIGHT;
    localparam int FRAME_AW    = $clog2(FRAME_WORDS);
    localparam int MEM_AW      = FRAME_AW + 1;
    localparam int AREA_W      = $clog2(FRAME_WORDS + 1);
    localparam int W_DIM_W     = $clog2(MAX_WIDTH + 1);
    localparam int H_DIM_W     = $clog2(MAX_HEIGHT + 1);
    localparam int WC_W        = (W_DIM_W > CFG_DATA_W) ? W_DIM_W : CFG_DATA_W;
    localparam int HC_W        = (H_DIM_W > CFG_DATA_W) ? H_DIM_W : CFG_DATA_W;
    localparam int XC_W        = (W_DIM_W > COORD_W + 1) ? W_DIM_W : COORD_W + 1;
    localparam int YC_W        = (H_DIM_W > COORD_W + 1) ? H_DIM_W : COORD_W + 1;
    localparam int CC_W        = (AREA_W > ADDR_W + 1) ? AREA_W : ADDR_W + 1;
    localparam int W_RST       = (RESET_WIDTH > MAX_WIDTH) ? MAX_WIDTH : RESET_WIDTH;
    localparam int H_RST       = (RESET_HEIGHT > MAX_HEIGHT) ? MAX_HEIGHT : RESET_HEIGHT;
    localparam int AREA_RST    = W_RST * H_RST;

    // ------------------------------------------------------------------
    // Configuration: registers hold the clamped frame size and its area
    // ------------------------------------------------------------------
    logic [W_DIM_W-1:0] width_reg,  width_next;
    logic [H_DIM_W-1:0] height_reg, height_next;
    logic [AREA_W-1:0]  area_reg,   area_next;
    logic [W_DIM_W-1:0] w_eff;
    logic [H_DIM_W-1:0] h_eff;

    always_comb
    begin
        if (cfg_data == '0)
            w_eff = W_DIM_W'(1);
        else if (WC_W'(cfg_data) > WC_W'(MAX_WIDTH))
            w_eff = W_DIM_W'(MAX_WIDTH);
        else
            w_eff = W_DIM_W'(cfg_data);

        if (cfg_data == '0)
            h_eff = H_DIM_W'(1);
        else if (HC_W'(cfg_data) > HC_W'(MAX_HEIGHT))
            h_eff = H_DIM_W'(MAX_HEIGHT);
        else
            h_eff = H_DIM_W'(cfg_data);

        width_next  = width_reg;
        height_next = height_reg;
        area_next   = area_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                REG_FRAME_WIDTH:
                begin
                    width_next = w_eff;
                    area_next  = AREA_W'(AREA_W'(w_eff) * AREA_W'(height_reg));
                end
                REG_FRAME_HEIGHT:
                begin
                    height_next = h_eff;
                    area_next   = AREA_W'(AREA_W'(width_reg) * AREA_W'(h_eff));
                end
                default:
                begin
                    width_next = width_reg;
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline handshake
    // ------------------------------------------------------------------
    logic s1_valid_reg, s1_valid_next;
    logic s2_valid_reg, s2_valid_next;
    logic s3_valid_reg, s3_valid_next;
    logic out_valid_reg, out_valid_next;

    logic in_fire;
    logic out_free;
    logic s1_move, s1_room;
    logic s2_move, s2_room;
    logic s3_move, s3_room;
    logic rd_hazard;

    // ------------------------------------------------------------------
    // Accept stage: address generation and frame bookkeeping
    // ------------------------------------------------------------------
    logic [ADDR_W-1:0]   cnt_reg, cnt_next;
    logic                front_reg, front_next;
    logic                is_warp_in;
    logic [FRAME_AW-1:0] a_tl_in, a_bl_in;
    logic                x_lo_ok, x_hi_ok, y_lo_ok, y_hi_ok;
    logic [CC_W-1:0]     cnt_plus1;
    logic                warp_done;
    logic                warp_wr_ok;
    logic                pix_wr_ok;

    assign in_fire    = in_valid & ~in_stall;
    assign is_warp_in = (command == CMD_WARP);

    assign a_tl_in = FRAME_AW'(FRAME_AW'(src_y) * FRAME_AW'(width_reg)) + FRAME_AW'(src_x);
    assign a_bl_in = a_tl_in + FRAME_AW'(width_reg);

    // Neighbours off the right or bottom edge read as zero
    assign x_lo_ok = XC_W'(src_x) < XC_W'(width_reg);
    assign x_hi_ok = (XC_W'(src_x) + XC_W'(1)) < XC_W'(width_reg);
    assign y_lo_ok = YC_W'(src_y) < YC_W'(height_reg);
    assign y_hi_ok = (YC_W'(src_y) + YC_W'(1)) < YC_W'(height_reg);

    assign cnt_plus1  = CC_W'(cnt_reg) + CC_W'(1);
    // also ends the frame when the counter already ran past a shrunk area
    assign warp_done  = cnt_plus1 >= CC_W'(area_reg);
    assign warp_wr_ok = CC_W'(cnt_reg) < CC_W'(FRAME_WORDS);
    assign pix_wr_ok  = CC_W'(pixel_addr) < CC_W'(area_reg);

    always_comb
    begin
        cnt_next   = cnt_reg;
        front_next = front_reg;
        if (in_fire && is_warp_in)
        begin
            if (warp_done)
            begin
                cnt_next   = '0;
                front_next = ~front_reg;
            end
            else
            begin
                cnt_next = cnt_reg + ADDR_W'(1);
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: memory read issue
    // ------------------------------------------------------------------
    logic                s1_warp_reg;
    logic                s1_front_reg;
    logic [FRAME_AW-1:0] s1_a_tl_reg, s1_a_bl_reg;
    logic [3:0]          s1_ok_reg;   // {br, bl, tr, tl}
    logic [WEIGHT_W-1:0] s1_wtl_reg, s1_wtr_reg, s1_wbl_reg, s1_wbr_reg;
    logic                s1_wr_en_reg;
    logic                s1_wr_bank_reg;
    logic [FRAME_AW-1:0] s1_wr_addr_reg;
    logic [PIX_W-1:0]    s1_wr_pix_reg;
    logic [ADDR_W-1:0]   s1_dest_reg;
    logic                s1_done_reg;

    logic [MEM_AW-1:0]   rd_key_tl, rd_key_tr, rd_key_bl, rd_key_br;
    logic [MEM_AW-1:0]   s2_wr_key, s3_wr_key;
    logic                hit_s2, hit_s3;

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_warp_reg    <= is_warp_in;
            s1_front_reg   <= front_reg;
            s1_a_tl_reg    <= a_tl_in;
            s1_a_bl_reg    <= a_bl_in;
            s1_ok_reg      <= {x_hi_ok & y_hi_ok, x_lo_ok & y_hi_ok,
                               x_hi_ok & y_lo_ok, x_lo_ok & y_lo_ok};
            s1_wtl_reg     <= weight_tl;
            s1_wtr_reg     <= weight_tr;
            s1_wbl_reg     <= weight_bl;
            s1_wbr_reg     <= weight_br;
            s1_wr_en_reg   <= is_warp_in ? warp_wr_ok : pix_wr_ok;
            s1_wr_bank_reg <= is_warp_in ? ~front_reg : front_reg;
            s1_wr_addr_reg <= is_warp_in ? FRAME_AW'(cnt_reg) : FRAME_AW'(pixel_addr);
            s1_wr_pix_reg  <= pixel_value;
            s1_dest_reg    <= cnt_reg;
            s1_done_reg    <= warp_done;
        end
    end

    assign rd_key_tl = {s1_front_reg, s1_a_tl_reg};
    assign rd_key_tr = {s1_front_reg, s1_a_tl_reg + FRAME_AW'(1)};
    assign rd_key_bl = {s1_front_reg, s1_a_bl_reg};
    assign rd_key_br = {s1_front_reg, s1_a_bl_reg + FRAME_AW'(1)};

    // ------------------------------------------------------------------
    // Stage 2: read data back, corner products
    // ------------------------------------------------------------------
    logic                s2_warp_reg;
    logic [3:0]          s2_ok_reg;
    logic [WEIGHT_W-1:0] s2_wtl_reg, s2_wtr_reg, s2_wbl_reg, s2_wbr_reg;
    logic                s2_wr_en_reg;
    logic                s2_wr_bank_reg;
    logic [FRAME_AW-1:0] s2_wr_addr_reg;
    logic [PIX_W-1:0]    s2_wr_pix_reg;
    logic [ADDR_W-1:0]   s2_dest_reg;
    logic                s2_done_reg;
    logic [PIX_W-1:0]    rd_tl, rd_tr, rd_bl, rd_br;
    logic [PIX_W-1:0]    px_tl, px_tr, px_bl, px_br;

    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            s2_warp_reg    <= s1_warp_reg;
            s2_ok_reg      <= s1_ok_reg;
            s2_wtl_reg     <= s1_wtl_reg;
            s2_wtr_reg     <= s1_wtr_reg;
            s2_wbl_reg     <= s1_wbl_reg;
            s2_wbr_reg     <= s1_wbr_reg;
            s2_wr_en_reg   <= s1_wr_en_reg;
            s2_wr_bank_reg <= s1_wr_bank_reg;
            s2_wr_addr_reg <= s1_wr_addr_reg;
            s2_wr_pix_reg  <= s1_wr_pix_reg;
            s2_dest_reg    <= s1_dest_reg;
            s2_done_reg    <= s1_done_reg;
        end
    end

    assign px_tl = s2_ok_reg[0] ? rd_tl : '0;
    assign px_tr = s2_ok_reg[1] ? rd_tr : '0;
    assign px_bl = s2_ok_reg[2] ? rd_bl : '0;
    assign px_br = s2_ok_reg[3] ? rd_br : '0;

    // ------------------------------------------------------------------
    // Stage 3: sum, saturate, write back frame
    // ------------------------------------------------------------------
    logic                s3_warp_reg;
    logic                s3_wr_en_reg;
    logic                s3_wr_bank_reg;
    logic [FRAME_AW-1:0] s3_wr_addr_reg;
    logic [PIX_W-1:0]    s3_wr_pix_reg;
    logic [ADDR_W-1:0]   s3_dest_reg;
    logic                s3_done_reg;
    logic [PROD_W-1:0]   s3_ptl_reg, s3_ptr_reg, s3_pbl_reg, s3_pbr_reg;
    logic [SUM_W-1:0]    s3_sum;
    logic [SUM_W-WEIGHT_W-1:0] s3_sum_hi;
    logic [PIX_W-1:0]    s3_result;

    logic                mem_wr_en;
    logic [MEM_AW-1:0]   mem_wr_addr;
    logic [PIX_W-1:0]    mem_wr_data;

    always_ff @(posedge clk)
    begin
        if (s2_move)
        begin
            s3_warp_reg    <= s2_warp_reg;
            s3_wr_en_reg   <= s2_wr_en_reg;
            s3_wr_bank_reg <= s2_wr_bank_reg;
            s3_wr_addr_reg <= s2_wr_addr_reg;
            s3_wr_pix_reg  <= s2_wr_pix_reg;
            s3_dest_reg    <= s2_dest_reg;
            s3_done_reg    <= s2_done_reg;
            s3_ptl_reg     <= PROD_W'(px_tl) * PROD_W'(s2_wtl_reg);
            s3_ptr_reg     <= PROD_W'(px_tr) * PROD_W'(s2_wtr_reg);
            s3_pbl_reg     <= PROD_W'(px_bl) * PROD_W'(s2_wbl_reg);
            s3_pbr_reg     <= PROD_W'(px_br) * PROD_W'(s2_wbr_reg);
        end
    end

    assign s3_sum    = SUM_W'(s3_ptl_reg) + SUM_W'(s3_ptr_reg)
                     + SUM_W'(s3_pbl_reg) + SUM_W'(s3_pbr_reg);
    assign s3_sum_hi = s3_sum[SUM_W-1:WEIGHT_W];
    assign s3_result = (|s3_sum_hi[SUM_W-WEIGHT_W-1:PIX_W]) ? PIX_MAX
                                                             : s3_sum_hi[PIX_W-1:0];

    // Rewritten each cycle the stage holds; the value does not change
    assign mem_wr_en   = s3_valid_reg & s3_wr_en_reg;
    assign mem_wr_addr = {s3_wr_bank_reg, s3_wr_addr_reg};
    assign mem_wr_data = s3_warp_reg ? s3_result : s3_wr_pix_reg;

    // ------------------------------------------------------------------
    // Read-after-write interlock: writes land in stage 3, reads in stage 1
    // ------------------------------------------------------------------
    assign s2_wr_key = {s2_wr_bank_reg, s2_wr_addr_reg};
    assign s3_wr_key = {s3_wr_bank_reg, s3_wr_addr_reg};

    assign hit_s2 = s2_valid_reg & s2_wr_en_reg &
                    ((s2_wr_key == rd_key_tl) | (s2_wr_key == rd_key_tr) |
                     (s2_wr_key == rd_key_bl) | (s2_wr_key == rd_key_br));
    assign hit_s3 = s3_valid_reg & s3_wr_en_reg &
                    ((s3_wr_key == rd_key_tl) | (s3_wr_key == rd_key_tr) |
                     (s3_wr_key == rd_key_bl) | (s3_wr_key == rd_key_br));

    assign rd_hazard = s1_warp_reg & (hit_s2 | hit_s3);

    assign out_free = ~out_valid_reg | ~out_stall;
    assign s3_move  = s3_valid_reg & (~s3_warp_reg | out_free);
    assign s3_room  = ~s3_valid_reg | s3_move;
    assign s2_move  = s2_valid_reg & s3_room;
    assign s2_room  = ~s2_valid_reg | s3_room;
    assign s1_move  = s1_valid_reg & ~rd_hazard & s2_room;
    assign s1_room  = ~s1_valid_reg | s1_move;
    assign in_stall = ~s1_room;

    always_comb
    begin
        s1_valid_next  = in_fire | (s1_valid_reg & ~s1_move);
        s2_valid_next  = s1_move | (s2_valid_reg & ~s2_move);
        s3_valid_next  = s2_move | (s3_valid_reg & ~s3_move);
        out_valid_next = (s3_move & s3_warp_reg) | (out_valid_reg & out_stall);
    end

    // ------------------------------------------------------------------
    // Frame memories: top row copy and bottom row copy
    // ------------------------------------------------------------------
    bfw_frame_mem #(
        .ADDR_BITS (MEM_AW)
    ) u_mem_top (
        .clk       (clk),
        .wr_en     (mem_wr_en),
        .wr_addr   (mem_wr_addr),
        .wr_data   (mem_wr_data),
        .rd_en     (s1_move),
        .rd_addr_a (rd_key_tl),
        .rd_addr_b (rd_key_tr),
        .rd_data_a (rd_tl),
        .rd_data_b (rd_tr)
    );

    bfw_frame_mem #(
        .ADDR_BITS (MEM_AW)
    ) u_mem_bot (
        .clk       (clk),
        .wr_en     (mem_wr_en),
        .wr_addr   (mem_wr_addr),
        .wr_data   (mem_wr_data),
        .rd_en     (s1_move),
        .rd_addr_a (rd_key_bl),
        .rd_addr_b (rd_key_br),
        .rd_data_a (rd_bl),
        .rd_data_b (rd_br)
    );

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    logic [PIX_W-1:0]  out_pixel_reg;
    logic [ADDR_W-1:0] dest_addr_reg;
    logic              frame_done_reg;

    always_ff @(posedge clk)
    begin
        if (s3_move && s3_warp_reg)
        begin
            out_pixel_reg  <= s3_result;
            dest_addr_reg  <= s3_dest_reg;
            frame_done_reg <= s3_done_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_pixel  = out_pixel_reg;
    assign dest_addr  = dest_addr_reg;
    assign frame_done = frame_done_reg;

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg     <= W_DIM_W'(W_RST);
            height_reg    <= H_DIM_W'(H_RST);
            area_reg      <= AREA_W'(AREA_RST);
            cnt_reg       <= '0;
            front_reg     <= 1'b0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            width_reg     <= width_next;
            height_reg    <= height_next;
            area_reg      <= area_next;
            cnt_reg       <= cnt_next;
            front_reg     <= front_next;
            s1_valid_reg  <= s1_valid_next;
            s2_valid_reg  <= s2_valid_next;
            s3_valid_reg  <= s3_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // A warp read never leaves while stage 2 still owes a write to a neighbour
    a_no_stale_s2: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_move && s1_warp_reg && s2_valid_reg && s2_wr_en_reg) |->
        ((s2_wr_key != rd_key_tl) && (s2_wr_key != rd_key_tr) &&
         (s2_wr_key != rd_key_bl) && (s2_wr_key != rd_key_br)))
        else $error("warp read overtook pending write in stage 2");

    // Same for the write being committed in stage 3
    a_no_stale_s3: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_move && s1_warp_reg && s3_valid_reg && s3_wr_en_reg) |->
        ((s3_wr_key != rd_key_tl) && (s3_wr_key != rd_key_tr) &&
         (s3_wr_key != rd_key_bl) && (s3_wr_key != rd_key_br)))
        else $error("warp read overtook pending write in stage 3");

    // An item held in stage 1 is neither dropped nor overwritten
    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_move) |=>
        (s1_valid_reg && $stable(s1_dest_reg) && $stable(s1_a_tl_reg)))
        else $error("stage 1 transaction lost while held");

endmodule
